// File: rtl/core/tma_pkg.sv
// tma_pkg: shared types and constants of the triple moving average ordering block
// no dependencies; used by the channel interfaces and every module under rtl/core
`default_nettype none

package tma_pkg;

  // payload widths
  localparam int PRICE_W = 24;
  localparam int CODE_W  = 3;

  // nominal window lengths, shrunk to the long window when that is shorter
  localparam int SHORT_NOM = 15;
  localparam int MID_NOM   = 30;

  // ranking of the three averages (s = short, m = mid, l = long)
  typedef enum logic [CODE_W-1:0] {
    ORD_NONE = 3'd0,  // tie for the largest
    ORD_SML  = 3'd1,
    ORD_SLM  = 3'd2,
    ORD_MSL  = 3'd3,
    ORD_MLS  = 3'd4,
    ORD_LSM  = 3'd5,
    ORD_LMS  = 3'd6
  } order_code_t;

endpackage

`default_nettype wire

// File: rtl/core/tma_in_if.sv
// tma_in_if: price sample channel, valid/ready handshake
// depends on tma_pkg
`default_nettype none

interface tma_in_if;
  import tma_pkg::*;

  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tma_out_if.sv
// tma_out_if: result channel carrying the three averages and the ordering code
// depends on tma_pkg
`default_nettype none

interface tma_out_if;
  import tma_pkg::*;

  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] avg_short;
  logic [PRICE_W-1:0] avg_mid;
  logic [PRICE_W-1:0] avg_long;
  logic [CODE_W-1:0]  order_code;

  modport source (output valid, output avg_short, output avg_mid, output avg_long,
                  output order_code, input ready);
  modport sink   (input valid, input avg_short, input avg_mid, input avg_long,
                  input order_code, output ready);
endinterface

`default_nettype wire

// File: rtl/core/triple_moving_average_order.sv
// triple_moving_average_order: short, mid and long simple moving averages of a price
// stream plus a code ranking them. One beat per cycle sustained while out_if.ready
// is high, set by the delay-line shift and running-sum update. Stages: sum update,
// reciprocal and cross products, output register; each stage stalls only when the
// next one is full. Synchronous reset clears the delay line, sums, sample count and
// valid bits; the block takes beats from the first cycle.
// depends on tma_pkg, tma_in_if, tma_out_if, tma_cell, tma_cdiv, tma_rank
`default_nettype none

module triple_moving_average_order #(
  parameter int LONG_WINDOW = 60
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tma_in_if.sink     in_if,
  tma_out_if.source  out_if
);
  import tma_pkg::*;

  localparam int SL    = (LONG_WINDOW < SHORT_NOM) ? LONG_WINDOW : SHORT_NOM;
  localparam int ML    = (LONG_WINDOW < MID_NOM) ? LONG_WINDOW : MID_NOM;
  localparam int S_W   = PRICE_W + $clog2(SL);
  localparam int M_W   = PRICE_W + $clog2(ML);
  localparam int L_W   = PRICE_W + $clog2(LONG_WINDOW);
  localparam int CNT_W = $clog2(LONG_WINDOW + 2);

  // handshake and stage control
  logic accept, s1_take, s2_take, out_take;
  logic s1_v_r, s2_v_r, out_v_r;

  // delay line taps
  logic [PRICE_W-1:0] taps [LONG_WINDOW];

  // running state
  logic [S_W-1:0]   sum_s_r, sum_s_nxt;
  logic [M_W-1:0]   sum_m_r, sum_m_nxt;
  logic [L_W-1:0]   sum_l_r, sum_l_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // stage 1: masked sums
  logic [S_W-1:0] es_r;
  logic [M_W-1:0] em_r;
  logic [L_W-1:0] el_r;

  // stage 2 results and output register
  logic [PRICE_W-1:0] q_s, q_m, q_l;
  order_code_t        code;
  logic [PRICE_W-1:0] avg_s_r, avg_m_r, avg_l_r;
  order_code_t        code_r;

  // ready ripples back from the output register
  assign out_take    = !out_v_r || out_if.ready;
  assign s2_take     = !s2_v_r || out_take;
  assign s1_take     = !s1_v_r || s2_take;
  assign in_if.ready = s1_take;
  assign accept      = in_if.valid && s1_take;

  // price delay line, newest sample in cell 0
  generate
    for (genvar i = 0; i < LONG_WINDOW; i++) begin : g_line
      if (i == 0) begin : g_head
        tma_cell u_cell (
          .clk(clk), .rst_n(rst_n), .shift(accept), .d(in_if.price), .q(taps[i])
        );
      end else begin : g_body
        tma_cell u_cell (
          .clk(clk), .rst_n(rst_n), .shift(accept), .d(taps[i-1]), .q(taps[i])
        );
      end
    end
  endgenerate

  // running window sums and saturating sample count
  always_comb begin
    sum_s_nxt = sum_s_r + S_W'(in_if.price) - S_W'(taps[SL-1]);
    sum_m_nxt = sum_m_r + M_W'(in_if.price) - M_W'(taps[ML-1]);
    sum_l_nxt = sum_l_r + L_W'(in_if.price) - L_W'(taps[LONG_WINDOW-1]);
    count_nxt = count_r;
    if (count_r != CNT_W'(LONG_WINDOW + 1)) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_s_r <= '0;
      sum_m_r <= '0;
      sum_l_r <= '0;
      count_r <= '0;
    end else if (accept) begin
      sum_s_r <= sum_s_nxt;
      sum_m_r <= sum_m_nxt;
      sum_l_r <= sum_l_nxt;
      count_r <= count_nxt;
    end
  end

  // stage 1: warm-up masking of the updated sums
  always_ff @(posedge clk) begin
    if (s1_take) begin
      es_r <= (count_r >= CNT_W'(SL)) ? sum_s_nxt : '0;
      em_r <= (count_r >= CNT_W'(ML)) ? sum_m_nxt : '0;
      el_r <= (count_r >= CNT_W'(LONG_WINDOW)) ? sum_l_nxt : '0;
    end
  end

  // stage 2: constant dividers and ranking
  tma_cdiv #(.DIVISOR(SL), .SUM_W(S_W)) u_div_s (
    .clk(clk), .adv(s2_take), .sum(es_r), .quot(q_s)
  );
  tma_cdiv #(.DIVISOR(ML), .SUM_W(M_W)) u_div_m (
    .clk(clk), .adv(s2_take), .sum(em_r), .quot(q_m)
  );
  tma_cdiv #(.DIVISOR(LONG_WINDOW), .SUM_W(L_W)) u_div_l (
    .clk(clk), .adv(s2_take), .sum(el_r), .quot(q_l)
  );

  tma_rank #(
    .SL(SL), .ML(ML), .LW(LONG_WINDOW), .S_W(S_W), .M_W(M_W), .L_W(L_W)
  ) u_rank (
    .clk(clk), .adv(s2_take), .es(es_r), .em(em_r), .el(el_r), .code(code)
  );

  // output register
  always_ff @(posedge clk) begin
    if (out_take) begin
      avg_s_r <= q_s;
      avg_m_r <= q_m;
      avg_l_r <= q_l;
      code_r  <= code;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_v_r <= accept;
      end
      if (s2_take) begin
        s2_v_r <= s1_v_r;
      end
      if (out_take) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  assign out_if.valid      = out_v_r;
  assign out_if.avg_short  = avg_s_r;
  assign out_if.avg_mid    = avg_m_r;
  assign out_if.avg_long   = avg_l_r;
  assign out_if.order_code = code_r;

  // nested windows: a longer window never sums less than a shorter one
  a_sums_nested: assert property (@(posedge clk) disable iff (!rst_n)
    (L_W'(sum_m_r) <= sum_l_r) && (M_W'(sum_s_r) <= sum_m_r))
    else $error("window sums not nested");

  // sample count never passes its saturation point
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LONG_WINDOW + 1))
    else $error("sample count beyond saturation");

  // a strict short > mid > long ranking agrees with the floored averages
  a_code_vs_avg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (code_r == ORD_SML)) |-> ((avg_s_r >= avg_m_r) && (avg_m_r >= avg_l_r)))
    else $error("ordering code disagrees with averages");

endmodule

`default_nettype wire

// File: rtl/core/tma_cell.sv
// tma_cell: one stage of the price delay line, shifts toward older samples on a beat
// depends on tma_pkg
`default_nettype none

module tma_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        shift,
  input  wire logic [tma_pkg::PRICE_W-1:0] d,
  output logic      [tma_pkg::PRICE_W-1:0] q
);
  import tma_pkg::*;

  logic [PRICE_W-1:0] price_r;
  logic [PRICE_W-1:0] price_nxt;

  // take the neighbor's sample on each accepted beat
  always_comb begin
    price_nxt = shift ? d : price_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      price_r <= '0;
    end else begin
      price_r <= price_nxt;
    end
  end

  assign q = price_r;

endmodule

`default_nettype wire

// File: rtl/core/tma_cdiv.sv
// tma_cdiv: floor division of a window sum by a constant window length
// reciprocal multiply in one registered stage, then one correction step
// depends on tma_pkg
`default_nettype none

module tma_cdiv #(
  parameter int DIVISOR = 15,
  parameter int SUM_W   = 28
) (
  input  wire logic                        clk,
  input  wire logic                        adv,
  input  wire logic [SUM_W-1:0]            sum,
  output logic      [tma_pkg::PRICE_W-1:0] quot
);
  import tma_pkg::*;

  // floor(2^SUM_W / DIVISOR) underestimates the quotient by at most one
  localparam int              REC_W  = SUM_W - $clog2(DIVISOR) + 1;
  localparam longint unsigned REC    = (64'd1 << SUM_W) / DIVISOR;
  localparam int              PROD_W = SUM_W + REC_W;

  logic [PROD_W-1:0]  prod_r;
  logic [SUM_W-1:0]   sum_r;
  logic [PRICE_W-1:0] q_est;
  logic [SUM_W-1:0]   rem;

  // reciprocal product stage
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= PROD_W'(sum) * PROD_W'(REC_W'(REC));
      sum_r  <= sum;
    end
  end

  // estimate and one-step correction
  always_comb begin
    q_est = PRICE_W'(prod_r >> SUM_W);
    rem   = sum_r - SUM_W'(SUM_W'(q_est) * SUM_W'(DIVISOR));
    quot  = q_est + PRICE_W'(rem >= SUM_W'(DIVISOR));
  end

endmodule

`default_nettype wire

// File: rtl/core/tma_rank.sv
// tma_rank: orders the three exact averages by cross-multiplied window sums
// registered products, then compares and code selection; depends on tma_pkg
`default_nettype none

module tma_rank #(
  parameter int SL  = 15,
  parameter int ML  = 30,
  parameter int LW  = 60,
  parameter int S_W = 28,
  parameter int M_W = 29,
  parameter int L_W = 30
) (
  input  wire logic                 clk,
  input  wire logic                 adv,
  input  wire logic [S_W-1:0]       es,
  input  wire logic [M_W-1:0]       em,
  input  wire logic [L_W-1:0]       el,
  output tma_pkg::order_code_t      code
);
  import tma_pkg::*;

  localparam int PW = L_W + $clog2(LW + 1);

  logic [PW-1:0] p_sm_r, p_ms_r, p_sl_r, p_ls_r, p_ml_r, p_lm_r;
  logic          gt_sm, gt_ms, gt_sl, gt_ls, gt_ml, gt_lm;

  // sums scaled pairwise to a common denominator
  always_ff @(posedge clk) begin
    if (adv) begin
      p_sm_r <= PW'(es) * PW'(ML);
      p_ms_r <= PW'(em) * PW'(SL);
      p_sl_r <= PW'(es) * PW'(LW);
      p_ls_r <= PW'(el) * PW'(SL);
      p_ml_r <= PW'(em) * PW'(LW);
      p_lm_r <= PW'(el) * PW'(ML);
    end
  end

  // strict pairwise orderings and the resulting code
  always_comb begin
    gt_sm = p_sm_r > p_ms_r;
    gt_ms = p_ms_r > p_sm_r;
    gt_sl = p_sl_r > p_ls_r;
    gt_ls = p_ls_r > p_sl_r;
    gt_ml = p_ml_r > p_lm_r;
    gt_lm = p_lm_r > p_ml_r;
    code  = ORD_NONE;
    if (gt_sm && gt_sl) begin
      code = gt_ml ? ORD_SML : ORD_SLM;
    end else if (gt_ms && gt_ml) begin
      code = gt_sl ? ORD_MSL : ORD_MLS;
    end else if (gt_lm && gt_ls) begin
      code = gt_sm ? ORD_LSM : ORD_LMS;
    end
  end

endmodule

`default_nettype wire
